### design/cpg_pkg.sv
// Shared types, constants and the CORDIC angle table of the circle point generator.
package cpg_pkg;

    // Default widths and queue depth
    localparam int PHASE_BITS_DEF  = 32;
    localparam int RADIUS_BITS_DEF = 16;
    localparam int QUEUE_DEPTH_DEF = 4;

    // Configuration port
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 32;
    localparam int INDEX_BITS     = 16;
    localparam int COUNT_BITS     = 16;

    // CORDIC constants: angles in binary turns, 32-bit angle word
    localparam int ANGLE_BITS   = 32;
    localparam int Z_BITS       = 34;
    localparam int CORDIC_ITERS = 30;
    localparam int FRAC_BITS    = 30;
    localparam logic [30:0] CORDIC_GAIN_Q30 = 31'd652032874;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_RADIUS      = 2'd0,
        REG_PHASE_STEP  = 2'd1,
        REG_START_PHASE = 2'd2,
        REG_POINT_COUNT = 2'd3
    } cfg_reg_t;

    // Per-point control that rides along with the phase
    typedef struct packed {
        logic [INDEX_BITS-1:0] index;
        logic                  last;
    } cpg_ctl_t;

    localparam logic [ANGLE_BITS-1:0] ATAN_TURNS [CORDIC_ITERS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
    };

endpackage

### design/cpg_front.sv
// Front end: accepts ticks, runs the phase accumulator and point counter.
module cpg_front import cpg_pkg::*; #(
    parameter int PHASE_BITS = PHASE_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  tick_valid,
    input  logic                  tick_restart,
    output logic                  tick_ready,
    input  logic [PHASE_BITS-1:0] phase_step,
    input  logic [PHASE_BITS-1:0] start_phase,
    input  logic [COUNT_BITS-1:0] point_count,
    input  logic                  q_full,
    output logic                  q_push,
    output logic [PHASE_BITS-1:0] q_phase,
    output cpg_ctl_t              q_ctl
);

    logic [PHASE_BITS-1:0] acc_reg, acc_next;
    logic [INDEX_BITS-1:0] cnt_reg, cnt_next;
    logic [PHASE_BITS-1:0] cur_phase;
    logic [INDEX_BITS-1:0] cur_cnt;
    logic [COUNT_BITS-1:0] count;
    logic                  last;

    assign tick_ready = !q_full;
    assign q_push     = tick_valid && tick_ready;

    // Point of this transaction; a restart reloads before computing
    always_comb begin
        cur_phase = tick_restart ? start_phase : acc_reg;
        cur_cnt   = tick_restart ? '0 : cnt_reg;
        count     = (point_count == '0) ? COUNT_BITS'(1) : point_count;
        last      = ({1'b0, cur_cnt} + 17'd1) >= {1'b0, count};
        q_phase     = cur_phase;
        q_ctl.index = cur_cnt;
        q_ctl.last  = last;
    end

    // Advance or wrap to the start of the run
    always_comb begin
        acc_next = acc_reg;
        cnt_next = cnt_reg;
        if (q_push) begin
            if (last) begin
                acc_next = start_phase;
                cnt_next = '0;
            end else begin
                acc_next = cur_phase + phase_step;
                cnt_next = cur_cnt + INDEX_BITS'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
            cnt_reg <= '0;
        end else begin
            acc_reg <= acc_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

### design/cpg_fifo.sv
// Short queue of pending points between front end and CORDIC pipeline.
module cpg_fifo import cpg_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             full,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign full     = (cnt_reg == CNT_W'(DEPTH));
    assign empty    = (cnt_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### design/cpg_cordic.sv
// Back end: pipelined rotation-mode CORDIC with output register and stall.
module cpg_cordic import cpg_pkg::*; #(
    parameter int PHASE_BITS  = PHASE_BITS_DEF,
    parameter int RADIUS_BITS = RADIUS_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [PHASE_BITS-1:0]  in_phase,
    input  cpg_ctl_t               in_ctl,
    input  logic [RADIUS_BITS-1:0] radius,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [RADIUS_BITS:0]   out_x,
    output logic [RADIUS_BITS:0]   out_y,
    output cpg_ctl_t               out_ctl
);

    localparam int W   = RADIUS_BITS + 33;
    localparam int RW  = W - FRAC_BITS;
    localparam int NST = CORDIC_ITERS + 1;

    logic signed [W-1:0]      x_reg [NST];
    logic signed [W-1:0]      y_reg [NST];
    logic signed [Z_BITS-1:0] z_reg [NST];
    logic                     neg_reg [NST];
    cpg_ctl_t                 ctl_reg [NST];
    logic                     vld_reg [NST];

    logic                     adv;
    logic [ANGLE_BITS-1:0]    ang;
    logic [ANGLE_BITS-1:0]    ang_fold;
    logic                     fold;
    logic signed [W-1:0]      x0;

    logic                     ov_reg;
    logic [RADIUS_BITS:0]     ox_reg, oy_reg;
    cpg_ctl_t                 octl_reg;

    // Whole pipeline moves when the output register is free or being taken
    assign adv       = !ov_reg || out_ready;
    assign in_ready  = adv;
    assign out_valid = ov_reg;
    assign out_x     = ox_reg;
    assign out_y     = oy_reg;
    assign out_ctl   = octl_reg;

    // Angle word: top 32 bits of the phase, left-aligned when narrower
    generate
        if (PHASE_BITS >= ANGLE_BITS) begin : g_ang_hi
            assign ang = in_phase[PHASE_BITS-1 -: ANGLE_BITS];
        end else begin : g_ang_lo
            assign ang = {in_phase, {(ANGLE_BITS - PHASE_BITS){1'b0}}};
        end
    endgenerate

    // Fold the left half plane onto the right one, negate at the end
    always_comb begin
        logic [ANGLE_BITS-1:0] probe;
        probe    = ang + 32'h4000_0000;
        fold     = probe[ANGLE_BITS-1];
        ang_fold = fold ? ang + 32'h8000_0000 : ang;
        x0       = W'($signed({1'b0, radius}) * $signed({1'b0, CORDIC_GAIN_Q30}));
    end

    // Entry stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (adv) begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            x_reg[0]   <= x0;
            y_reg[0]   <= '0;
            z_reg[0]   <= Z_BITS'($signed(ang_fold));
            neg_reg[0] <= fold;
            ctl_reg[0] <= in_ctl;
        end
    end

    // One micro-rotation per stage
    genvar gi;
    generate
        for (gi = 0; gi < CORDIC_ITERS; gi++) begin : g_iter
            logic signed [W-1:0]      x_next, y_next;
            logic signed [Z_BITS-1:0] z_next;
            logic signed [Z_BITS-1:0] step;

            always_comb begin
                step = $signed(Z_BITS'(ATAN_TURNS[gi]));
                if (!z_reg[gi][Z_BITS-1]) begin
                    x_next = x_reg[gi] - (y_reg[gi] >>> gi);
                    y_next = y_reg[gi] + (x_reg[gi] >>> gi);
                    z_next = z_reg[gi] - step;
                end else begin
                    x_next = x_reg[gi] + (y_reg[gi] >>> gi);
                    y_next = y_reg[gi] - (x_reg[gi] >>> gi);
                    z_next = z_reg[gi] + step;
                end
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    vld_reg[gi+1] <= 1'b0;
                end else if (adv) begin
                    vld_reg[gi+1] <= vld_reg[gi];
                end
            end

            always_ff @(posedge aclk) begin
                if (adv) begin
                    x_reg[gi+1]   <= x_next;
                    y_reg[gi+1]   <= y_next;
                    z_reg[gi+1]   <= z_next;
                    neg_reg[gi+1] <= neg_reg[gi];
                    ctl_reg[gi+1] <= ctl_reg[gi];
                end
            end
        end
    endgenerate

    // Round half up, clamp to the radius, undo the fold
    function automatic logic [RADIUS_BITS:0] finish(input logic signed [W-1:0] v,
                                                    input logic [RADIUS_BITS-1:0] r,
                                                    input logic neg);
        logic signed [W-1:0]  sum;
        logic signed [RW-1:0] q;
        logic signed [RW-1:0] rs;
        sum = v + (W'(1) <<< (FRAC_BITS - 1));
        q   = sum[W-1:FRAC_BITS];
        rs  = $signed(RW'({1'b0, r}));
        if (q > rs) begin
            q = rs;
        end else if (q < -rs) begin
            q = -rs;
        end
        if (neg) begin
            q = -q;
        end
        return q[RADIUS_BITS:0];
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ov_reg <= 1'b0;
        end else if (adv) begin
            ov_reg <= vld_reg[NST-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            ox_reg   <= finish(x_reg[NST-1], radius, neg_reg[NST-1]);
            oy_reg   <= finish(y_reg[NST-1], radius, neg_reg[NST-1]);
            octl_reg <= ctl_reg[NST-1];
        end
    end

endmodule

### design/circle_point_generator.sv
// Top level of the circle point generator: config registers, front end, queue, CORDIC.
//
// Usage:
//   Each transaction on the s_ channel is one tick; s_tdata[0] = restart. A tick
//   with restart set begins a new run at start_phase with index 0. Every tick
//   gives one transaction on the m_ channel: x = radius*cos(phase),
//   y = radius*sin(phase), the point index, and m_tlast on the final point of
//   the run, after which the phase returns to start_phase.
//   Registers are written through cfg_wr_en / cfg_index / cfg_wdata while idle.
//   Throughput: one point per clock while m_tready is high. Path from tick acceptance
//   to m_tvalid: the queue, the entry stage, 30 CORDIC stages and the
//   output register. The phase accumulator add and the point counter feed back on themselves.
//   Reset (aresetn low, synchronous) clears the accumulator, counter, queue and
//   pipeline valids; registers return to radius 0, step 0, start 0, count 1.
//   When m_tready is low the pipeline holds; the queue between the front end
//   and the CORDIC still takes ticks until it is full, then s_tready drops.
module circle_point_generator import cpg_pkg::*; #(
    parameter int PHASE_BITS  = PHASE_BITS_DEF,
    parameter int RADIUS_BITS = RADIUS_BITS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    // fields from bit 0: restart
    input  logic [7:0]                s_tdata,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // fields from bit 0: x_coord, y_coord, point_index
    output logic [((2*(RADIUS_BITS+1)+INDEX_BITS+7)/8)*8-1:0] m_tdata,
    output logic                      m_tlast,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    input  logic                      cfg_wr_en,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_wdata
);

    localparam int DATA_W  = ((2*(RADIUS_BITS+1)+INDEX_BITS+7)/8)*8;
    localparam int CTL_W   = $bits(cpg_ctl_t);
    localparam int ENTRY_W = PHASE_BITS + CTL_W;

    logic [RADIUS_BITS-1:0] radius_reg;
    logic [PHASE_BITS-1:0]  phase_step_reg;
    logic [PHASE_BITS-1:0]  start_phase_reg;
    logic [COUNT_BITS-1:0]  point_count_reg;

    logic                   q_push, q_pop, q_full, q_empty;
    logic [PHASE_BITS-1:0]  push_phase, pop_phase;
    cpg_ctl_t               push_ctl, pop_ctl;
    logic [ENTRY_W-1:0]     pop_entry;
    logic                   back_ready;

    logic [RADIUS_BITS:0]   x_out, y_out;
    cpg_ctl_t               out_ctl;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg      <= '0;
            phase_step_reg  <= '0;
            start_phase_reg <= '0;
            point_count_reg <= COUNT_BITS'(1);
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_index))
                REG_RADIUS:      radius_reg      <= RADIUS_BITS'(cfg_wdata[15:0]);
                REG_PHASE_STEP:  phase_step_reg  <= PHASE_BITS'(cfg_wdata);
                REG_START_PHASE: start_phase_reg <= PHASE_BITS'(cfg_wdata);
                REG_POINT_COUNT: point_count_reg <= cfg_wdata[COUNT_BITS-1:0];
                default: ;
            endcase
        end
    end

    cpg_front #(
        .PHASE_BITS (PHASE_BITS)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .tick_valid   (s_tvalid),
        .tick_restart (s_tdata[0]),
        .tick_ready   (s_tready),
        .phase_step   (phase_step_reg),
        .start_phase  (start_phase_reg),
        .point_count  (point_count_reg),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_phase      (push_phase),
        .q_ctl        (push_ctl)
    );

    cpg_fifo #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data ({push_phase, push_ctl}),
        .pop       (q_pop),
        .pop_data  (pop_entry),
        .full      (q_full),
        .empty     (q_empty)
    );

    assign pop_phase = pop_entry[ENTRY_W-1:CTL_W];
    assign pop_ctl   = pop_entry[CTL_W-1:0];
    assign q_pop     = back_ready && !q_empty;

    cpg_cordic #(
        .PHASE_BITS  (PHASE_BITS),
        .RADIUS_BITS (RADIUS_BITS)
    ) u_cordic (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (!q_empty),
        .in_ready  (back_ready),
        .in_phase  (pop_phase),
        .in_ctl    (pop_ctl),
        .radius    (radius_reg),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_x     (x_out),
        .out_y     (y_out),
        .out_ctl   (out_ctl)
    );

    assign m_tdata = DATA_W'({out_ctl.index, y_out, x_out});
    assign m_tlast = out_ctl.last;

    // Queue status never claims both full and empty
    a_queue_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_full && q_empty))
        else $error("queue reports full and empty at once");

    // A pop is only issued on a nonempty queue
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_empty)
        else $error("queue popped while empty");

    // A restart tick enters the queue with index zero
    a_restart_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tdata[0]) |-> (q_push && push_ctl.index == '0))
        else $error("restart did not clear the point index");

    // A full queue holds the input side off
    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        q_full |-> !s_tready)
        else $error("tick accepted while queue full");

endmodule

### sim/circle_point_generator_checker.sv
`timescale 1ns / 100ps
// Stream checker for the circle point generator: tracks registers, predicts points, compares.
module circle_point_generator_checker import cpg_pkg::*; #(
    parameter int TDATA_BITS = ((2*(RADIUS_BITS_DEF+1)+INDEX_BITS+7)/8)*8
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    // fields from bit 0: restart
    input  logic [7:0]                s_tdata,
    input  logic                      s_tvalid,
    input  logic                      s_tready,
    // fields from bit 0: x_coord, y_coord, point_index
    input  logic [TDATA_BITS-1:0]     m_tdata,
    input  logic                      m_tlast,
    input  logic                      m_tvalid,
    input  logic                      m_tready,
    input  logic                      cfg_wr_en,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_wdata,
    output int                        fail_count,
    output int                        pending
);

    localparam int COORD_BITS = RADIUS_BITS_DEF + 1;
    localparam int ROT_STEPS  = 30;
    localparam longint GAIN_Q30 = 64'sd652032874;

    typedef struct packed {
        logic [COORD_BITS-1:0] x_coord;
        logic [COORD_BITS-1:0] y_coord;
        logic [INDEX_BITS-1:0] point_index;
        logic                  last;
    } point_t;

    // atan(2^-i) in binary turns, 32-bit angle word
    localparam logic [31:0] ROT_ANGLE [ROT_STEPS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
    };

    // Register copies and oscillator state
    logic [RADIUS_BITS_DEF-1:0] radius_q;
    logic [PHASE_BITS_DEF-1:0]  step_q;
    logic [PHASE_BITS_DEF-1:0]  start_q;
    logic [COUNT_BITS-1:0]      count_q;
    logic [PHASE_BITS_DEF-1:0]  phase_acc;
    logic [COUNT_BITS-1:0]      point_ctr;

    point_t points_due [$];

    function automatic void clear_model();
        radius_q  = '0;
        step_q    = '0;
        start_q   = '0;
        count_q   = COUNT_BITS'(1);
        phase_acc = '0;
        point_ctr = '0;
    endfunction

    function automatic void write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                                      input logic [CFG_DATA_BITS-1:0] data);
        case (cfg_reg_t'(idx))
            REG_RADIUS:      radius_q = data[RADIUS_BITS_DEF-1:0];
            REG_PHASE_STEP:  step_q   = data[PHASE_BITS_DEF-1:0];
            REG_START_PHASE: start_q  = data[PHASE_BITS_DEF-1:0];
            REG_POINT_COUNT: count_q  = data[COUNT_BITS-1:0];
            default: ;
        endcase
    endfunction

    // Rotation-mode CORDIC on the folded angle, rounded and clamped to the radius
    function automatic void rotate_point(input logic [31:0] phase,
                                         input logic [RADIUS_BITS_DEF-1:0] r,
                                         output logic [COORD_BITS-1:0] x_out,
                                         output logic [COORD_BITS-1:0] y_out);
        logic [31:0] ang;
        logic        flip;
        longint      cx, cy, cz, nx, rr;
        ang  = phase;
        flip = 1'b0;
        // angle in [1/4, 3/4) turn: rotate by half a turn and negate afterwards
        if (ang[31] ^ ang[30]) begin
            ang  = ang + 32'h8000_0000;
            flip = 1'b1;
        end
        rr = longint'(r);
        cz = longint'($signed(ang));
        cx = rr * GAIN_Q30;
        cy = 0;
        for (int i = 0; i < ROT_STEPS; i++) begin
            if (cz >= 0) begin
                nx = cx - (cy >>> i);
                cy = cy + (cx >>> i);
                cz = cz - longint'(ROT_ANGLE[i]);
            end else begin
                nx = cx + (cy >>> i);
                cy = cy - (cx >>> i);
                cz = cz + longint'(ROT_ANGLE[i]);
            end
            cx = nx;
        end
        cx = (cx + (64'sd1 <<< 29)) >>> 30;
        cy = (cy + (64'sd1 <<< 29)) >>> 30;
        if (cx > rr) cx = rr;
        else if (cx < -rr) cx = -rr;
        if (cy > rr) cy = rr;
        else if (cy < -rr) cy = -rr;
        if (flip) begin
            cx = -cx;
            cy = -cy;
        end
        x_out = cx[COORD_BITS-1:0];
        y_out = cy[COORD_BITS-1:0];
    endfunction

    // One tick: optional restart, compute the point, then advance or wrap
    function automatic point_t next_point(input logic restart);
        point_t                pt;
        logic [COUNT_BITS-1:0] eff_count;
        if (restart) begin
            phase_acc = start_q;
            point_ctr = '0;
        end
        eff_count = (count_q == '0) ? COUNT_BITS'(1) : count_q;
        rotate_point(phase_acc, radius_q, pt.x_coord, pt.y_coord);
        pt.point_index = point_ctr;
        pt.last = ({1'b0, point_ctr} + 1'b1) >= {1'b0, eff_count};
        if (pt.last) begin
            point_ctr = '0;
            phase_acc = start_q;
        end else begin
            point_ctr = point_ctr + 1'b1;
            phase_acc = phase_acc + step_q;
        end
        return pt;
    endfunction

    task automatic check_point(input point_t got);
        point_t want;
        if (points_due.size() == 0) begin
            $error("unexpected result transaction: x_coord %0d y_coord %0d point_index %0d",
                   $signed(got.x_coord), $signed(got.y_coord), got.point_index);
            fail_count++;
        end else begin
            want = points_due.pop_front();
            if (got.x_coord !== want.x_coord) begin
                $error("x_coord: expected %0d, actual %0d",
                       $signed(want.x_coord), $signed(got.x_coord));
                fail_count++;
            end
            if (got.y_coord !== want.y_coord) begin
                $error("y_coord: expected %0d, actual %0d",
                       $signed(want.y_coord), $signed(got.y_coord));
                fail_count++;
            end
            if (got.point_index !== want.point_index) begin
                $error("point_index: expected %0d, actual %0d",
                       want.point_index, got.point_index);
                fail_count++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0b, actual %0b", want.last, got.last);
                fail_count++;
            end
        end
    endtask

    // Watch both channels and the config port at each rising edge
    always @(posedge aclk) begin
        point_t got;
        point_t due;
        if (!aresetn) begin
            clear_model();
            points_due.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got.x_coord     = m_tdata[COORD_BITS-1:0];
                got.y_coord     = m_tdata[2*COORD_BITS-1:COORD_BITS];
                got.point_index = m_tdata[2*COORD_BITS+INDEX_BITS-1:2*COORD_BITS];
                got.last        = m_tlast;
                check_point(got);
            end
            if (s_tvalid && s_tready) begin
                due        = next_point(s_tdata[0]);
                points_due = {points_due, due};
            end
            if (cfg_wr_en) begin
                write_reg(cfg_index, cfg_wdata);
            end
        end
        pending = points_due.size();
    end

endmodule

### sim/circle_point_generator_tb.sv
`timescale 1ns / 100ps
// Testbench top of the circle point generator: clock, reset, stimulus and verdict.
module circle_point_generator_tb;
    import cpg_pkg::*;

    localparam int TDATA_BITS   = ((2*(RADIUS_BITS_DEF+1)+INDEX_BITS+7)/8)*8;
    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 7;
    localparam int RANDOM_ITEMS = 900;
    localparam int CALM_ITEMS   = 120;   // closing stretch with no idling
    localparam int HOLD_AFTER   = 300;   // ticks sent before the long sink hold-off
    localparam int HOLD_CYCLES  = 150;
    localparam int SETTLE       = 4;     // idle cycles before config writes
    localparam int TAIL_CYCLES  = 40;    // pipeline latency plus margin
    localparam longint TIMEOUT_NS = 64'd4_000_000;

    logic                      aclk      = 1'b0;
    logic                      aresetn   = 1'b0;
    logic [7:0]                s_tdata   = '0;
    logic                      s_tvalid  = 1'b0;
    logic                      s_tready;
    logic [TDATA_BITS-1:0]     m_tdata;
    logic                      m_tlast;
    logic                      m_tvalid;
    logic                      m_tready  = 1'b0;
    logic                      cfg_wr_en = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_wdata = '0;

    int fail_count;
    int pending;
    int sent_count = 0;
    bit no_idle    = 1'b0;

    always #(CLK_HALF) aclk = ~aclk;

    circle_point_generator u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    circle_point_generator_checker #(.TDATA_BITS(TDATA_BITS)) u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tdata    (s_tdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Offer one tick, with an occasional gap ahead of it
    task automatic send_tick(input logic restart);
        @(negedge aclk);
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, restart};
        do @(posedge aclk); while (!s_tready);
        sent_count++;
    endtask

    // Stop offering and wait until every point has come back
    task automatic drain_points();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_BITS-1:0] data);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Random register settings for one phase, extremes weighted in
    task automatic pick_settings(input bit write_all);
        logic [15:0] hi;
        logic [31:0] val;
        hi = 16'($urandom());
        if (write_all || $urandom_range(0, 1)) begin
            case ($urandom_range(0, 5))
                0:       val = {hi, 16'h0000};
                1:       val = {hi, 16'hFFFF};
                2:       val = {hi, 16'($urandom_range(1, 15))};
                default: val = $urandom();
            endcase
            write_reg(REG_RADIUS, val);
        end
        if (write_all || $urandom_range(0, 1)) begin
            case ($urandom_range(0, 5))
                0:       val = 32'h0000_0000;
                1:       val = 32'hFFFF_FFFF;
                2:       val = $urandom_range(0, 256);
                3:       val = {2'($urandom()), 30'h0} + $urandom_range(0, 3) - 1;
                default: val = $urandom();
            endcase
            write_reg(REG_PHASE_STEP, val);
        end
        if (write_all || $urandom_range(0, 1)) begin
            case ($urandom_range(0, 4))
                0:       val = 32'h0000_0000;
                1:       val = 32'hFFFF_FFFF;
                default: val = $urandom();
            endcase
            write_reg(REG_START_PHASE, val);
        end
        if (write_all || $urandom_range(0, 1)) begin
            case ($urandom_range(0, 7))
                0:       val = {hi, 16'h0000};
                1:       val = {hi, 16'hFFFF};
                2:       val = {hi, 16'h0001};
                3:       val = $urandom();
                default: val = {hi, 16'($urandom_range(2, 24))};
            endcase
            write_reg(REG_POINT_COUNT, val);
        end
    endtask

    // Result sink: random stall bursts, one long hold-off, no stalls at the end
    initial begin : result_sink
        bit held;
        held = 1'b0;
        forever begin
            @(negedge aclk);
            if (!held && !no_idle && sent_count >= HOLD_AFTER) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
            end else if (!no_idle && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 6) - 1) @(negedge aclk);
            end else begin
                m_tready <= 1'b1;
                if (!no_idle) repeat ($urandom_range(0, 30)) @(negedge aclk);
            end
        end
    end

    initial begin : stimulus
        int  left;
        int  n;
        bit  first;
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset values: radius zero, every point last
        send_tick(1'b0);
        send_tick(1'b1);

        // Full radius (upper data bits dropped), quarter-turn steps with accumulator wrap
        drain_points();
        write_reg(REG_RADIUS, 32'hFFFF_FFFF);
        write_reg(REG_PHASE_STEP, 32'h4000_0000);
        write_reg(REG_START_PHASE, 32'h0000_0000);
        write_reg(REG_POINT_COUNT, 32'd12);
        send_tick(1'b1);
        repeat (6) send_tick(1'b0);

        // New start phase is not loaded yet; count lowered below the counter forces a wrap
        drain_points();
        write_reg(REG_START_PHASE, 32'h7FFF_FFFF);
        write_reg(REG_PHASE_STEP, 32'hC000_0001);
        write_reg(REG_POINT_COUNT, 32'd3);
        repeat (4) send_tick(1'b0);

        // Zero point count acts as one, tiny radius
        drain_points();
        write_reg(REG_RADIUS, 32'hFFFE_0001);
        write_reg(REG_POINT_COUNT, 32'h5A5A_0000);
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b0);

        // Angles straddling the quarter-turn fold
        drain_points();
        write_reg(REG_RADIUS, 32'h0000_FFFF);
        write_reg(REG_START_PHASE, 32'h3FFF_FFFF);
        write_reg(REG_PHASE_STEP, 32'h0000_0002);
        write_reg(REG_POINT_COUNT, 32'd2);
        send_tick(1'b1);
        send_tick(1'b0);

        // Random phases of ticks between register changes
        left  = RANDOM_ITEMS;
        first = 1'b1;
        while (left > 0) begin
            if (left <= CALM_ITEMS) no_idle = 1'b1;
            drain_points();
            pick_settings(first);
            n = $urandom_range(20, 90);
            if (n > left) n = left;
            for (int i = 0; i < n; i++) begin
                if (i == 0) send_tick(1'($urandom_range(0, 1)));
                else send_tick($urandom_range(0, 11) == 0);
            end
            left -= n;
            first = 1'b0;
        end

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (TAIL_CYCLES) @(negedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("end of test: mismatches");
        $finish;
    end

endmodule
